FILE: rtl/ssc_pkg.sv
package ssc_pkg;

   localparam int LineCapacityDefault = 128;

   localparam int DATA_W = 8;
   localparam int VALUE_W = 32;
   localparam int PHASE_W = 3;
   localparam int POS_W = 3;

   // parse phase codes
   localparam logic [PHASE_W-1:0] PH_PREFIX = 3'd0;
   localparam logic [PHASE_W-1:0] PH_BLANKS = 3'd1;
   localparam logic [PHASE_W-1:0] PH_SIGN   = 3'd2;
   localparam logic [PHASE_W-1:0] PH_DIGITS = 3'd3;
   localparam logic [PHASE_W-1:0] PH_DONE   = 3'd4;
   localparam logic [PHASE_W-1:0] PH_REJECT = 3'd5;

   localparam logic [POS_W-1:0] PREFIX_LEN = 3'd7;

   localparam logic [DATA_W-1:0] CHAR_NUL   = 8'd0;
   localparam logic [DATA_W-1:0] CHAR_TAB   = 8'd9;
   localparam logic [DATA_W-1:0] CHAR_LF    = 8'd10;
   localparam logic [DATA_W-1:0] CHAR_VT    = 8'd11;
   localparam logic [DATA_W-1:0] CHAR_FF    = 8'd12;
   localparam logic [DATA_W-1:0] CHAR_CR    = 8'd13;
   localparam logic [DATA_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [DATA_W-1:0] CHAR_PLUS  = 8'd43;
   localparam logic [DATA_W-1:0] CHAR_MINUS = 8'd45;
   localparam logic [DATA_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [DATA_W-1:0] CHAR_NINE  = 8'd57;

   localparam logic [VALUE_W-1:0] MAG_LIMIT = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] POS_MAX   = 32'h7fff_ffff;

   // one parsed command on its way to the output register
   typedef struct packed {
      logic                      valid;
      logic signed [VALUE_W-1:0] value;
      logic                      clamped;
   } ssc_result_type;

   // "@speed%" one character per position
   function automatic logic [DATA_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
      logic [DATA_W-1:0] ch;
      ch = CHAR_NUL;
      case (pos)
         3'd0: ch = 8'h40;
         3'd1: ch = 8'h73;
         3'd2: ch = 8'h70;
         3'd3: ch = 8'h65;
         3'd4: ch = 8'h65;
         3'd5: ch = 8'h64;
         3'd6: ch = 8'h25;
         default: ch = CHAR_NUL;
      endcase
      return ch;
   endfunction

endpackage

FILE: rtl/ssc_parser.sv
module ssc_parser
   import ssc_pkg::*;
#(
   parameter int LINE_CAPACITY = LineCapacityDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [DATA_W-1:0]   rx_char,
   output ssc_result_type      result
);

   localparam int LEN_W = $clog2(LINE_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);

   logic [LEN_W-1:0]   len_ff, len_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic               ovf_ff, ovf_in;

   logic               is_term;
   logic               is_blank;
   logic               is_digit;
   logic [VALUE_W+3:0] mag_x10;
   logic [VALUE_W-1:0] dig_mag;
   logic               dig_ovf;

   assign is_term  = (rx_char == CHAR_CR) || (rx_char == CHAR_LF);
   assign is_blank = (rx_char == CHAR_SPACE) || (rx_char == CHAR_TAB) ||
                     (rx_char == CHAR_VT) || (rx_char == CHAR_FF);
   assign is_digit = (rx_char >= CHAR_ZERO) && (rx_char <= CHAR_NINE);

   // magnitude * 10 + digit, saturating just past the positive range
   assign mag_x10 = ({4'b0, mag_ff} << 3) + ({4'b0, mag_ff} << 1) +
                    {{(VALUE_W){1'b0}}, rx_char[3:0]};
   assign dig_ovf = mag_x10 > {4'b0, MAG_LIMIT};
   assign dig_mag = dig_ovf ? MAG_LIMIT : mag_x10[VALUE_W-1:0];

   always_comb begin
      len_in   = len_ff;
      phase_in = phase_ff;
      pos_in   = pos_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      result   = '0;
      if (is_term) begin
         if ((phase_ff == PH_DIGITS) || (phase_ff == PH_DONE)) begin
            result.valid = 1'b1;
            if (neg_ff) begin
               result.clamped = ovf_ff;
               result.value   = ovf_ff ? MAG_LIMIT : (~mag_ff + 32'd1);
            end else begin
               result.clamped = ovf_ff || mag_ff[VALUE_W-1];
               result.value   = result.clamped ? POS_MAX : mag_ff;
            end
         end
         len_in   = '0;
         phase_in = PH_PREFIX;
         pos_in   = '0;
         mag_in   = '0;
         neg_in   = 1'b0;
         ovf_in   = 1'b0;
      end else if (len_ff < LEN_MAX) begin
         len_in = len_ff + 1'b1;
         if (rx_char == CHAR_NUL) begin
            // nul ends the content; a started number stands
            if ((phase_ff == PH_DIGITS) || (phase_ff == PH_DONE)) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_REJECT;
            end
         end else begin
            unique case (phase_ff)
               PH_PREFIX: begin
                  if ((pos_ff < PREFIX_LEN) && (rx_char == prefix_char(pos_ff))) begin
                     pos_in = pos_ff + 1'b1;
                     if (pos_in == PREFIX_LEN) begin
                        phase_in = PH_BLANKS;
                     end
                  end else begin
                     phase_in = PH_REJECT;
                  end
               end
               PH_BLANKS: begin
                  if (is_blank) begin
                     phase_in = PH_BLANKS;
                  end else if (rx_char == CHAR_PLUS) begin
                     phase_in = PH_SIGN;
                  end else if (rx_char == CHAR_MINUS) begin
                     neg_in   = 1'b1;
                     phase_in = PH_SIGN;
                  end else if (is_digit) begin
                     mag_in   = dig_mag;
                     ovf_in   = ovf_ff | dig_ovf;
                     phase_in = PH_DIGITS;
                  end else begin
                     phase_in = PH_REJECT;
                  end
               end
               PH_SIGN: begin
                  if (is_digit) begin
                     mag_in   = dig_mag;
                     ovf_in   = ovf_ff | dig_ovf;
                     phase_in = PH_DIGITS;
                  end else begin
                     phase_in = PH_REJECT;
                  end
               end
               PH_DIGITS: begin
                  if (is_digit) begin
                     mag_in = dig_mag;
                     ovf_in = ovf_ff | dig_ovf;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         phase_ff <= PH_PREFIX;
         pos_ff   <= '0;
         mag_ff   <= '0;
         neg_ff   <= 1'b0;
         ovf_ff   <= 1'b0;
      end else if (take) begin
         len_ff   <= len_in;
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         mag_ff   <= mag_in;
         neg_ff   <= neg_in;
         ovf_ff   <= ovf_in;
      end
   end

endmodule

FILE: rtl/ssc_out_reg.sv
module ssc_out_reg
   import ssc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  ssc_result_type            result,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output logic signed [VALUE_W-1:0] value,
   output logic                      clamped,
   output logic                      room
);

   logic                      valid_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic                      clamped_ff;

   // a new word may enter when the register is empty or draining now
   assign room       = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign value      = value_ff;
   assign clamped    = clamped_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load && result.valid) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         value_ff   <= result.value;
         clamped_ff <= result.clamped;
      end
   end

endmodule

FILE: rtl/serial_speed_command_parser_top.sv
// speed command line parser: one received byte per word in, one signed speed word out
// result: registered; the word shows on rsp in the cycle after the line terminator is taken
// throughput: one byte per cycle; a byte waits only while a finished word is held back
// reset: synchronous, active high; clears the line state and drops any pending result
module serial_speed_command_parser_top
   import ssc_pkg::*;
#(
   parameter int LINE_CAPACITY = LineCapacityDefault
) (
   input  logic                      clock,
   input  logic                      reset,
   // byte stream in
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [DATA_W-1:0]         req_tdata,   // [7:0] rx_char
   // parsed command out
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic signed [VALUE_W-1:0] rsp_tdata,   // [31:0] target speed
   output logic                      rsp_tuser    // [0] value_clamped
);

   ssc_result_type result;
   logic           room;
   logic           take;

   // bytes flow whenever the output register can absorb a word this cycle
   assign req_tready = room;
   assign take       = req_tvalid && room;

   // per-byte parse: prefix match, blanks, sign, decimal accumulate
   ssc_parser #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_char (req_tdata),
      .result  (result)
   );

   // result register, parts the parser from a stalled consumer
   ssc_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .result     (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .value      (rsp_tdata),
      .clamped    (rsp_tuser),
      .room       (room)
   );

endmodule

FILE: tb/sv/serial_speed_command_parser_top_test.sv
module serial_speed_command_parser_top_test;
   import ssc_pkg::*;

   localparam int LineCap = LineCapacityDefault;
   localparam int CycleLimit = 400000;
   localparam int ReportLimit = 10;
   // command prefix, first character in the top byte
   localparam logic [55:0] TagText = "@speed%";
   localparam int TagLen = 7;

   // one expected speed word
   typedef struct {
      logic signed [VALUE_W-1:0] speed;
      logic                      clamped;
   } speed_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [DATA_W-1:0]         req_tdata = '0;     // [7:0] rx_char
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic signed [VALUE_W-1:0] rsp_tdata;          // [31:0] target speed
   logic                      rsp_tuser;          // [0] value_clamped

   serial_speed_command_parser_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // speed words predicted but not yet seen on rsp
   speed_word_type speed_words [$];

   // line tracking state of the predictor
   int unsigned            line_len;
   logic [PHASE_W-1:0]     phase;
   int unsigned            tag_pos;
   logic [VALUE_W-1:0]     mag;
   logic                   neg;
   logic                   ovf;

   // run controls shared by the stimulus and the receiver
   bit gaps_on = 1'b0;
   bit stalls_on = 1'b0;
   int hold_cycles = 0;

   int bytes_sent = 0;
   int words_checked = 0;
   int words_clamped = 0;
   int fault_count = 0;
   int cycle_count = 0;
   speed_word_type want;

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   function automatic logic [7:0] tag_char(input int unsigned pos);
      return TagText[8*(TagLen-1-pos) +: 8];
   endfunction

   function void clear_line_state();
      line_len = 0;
      phase = PH_PREFIX;
      tag_pos = 0;
      mag = '0;
      neg = 1'b0;
      ovf = 1'b0;
   endfunction

   // magnitude sticks at 2^31 once the number runs past it
   function void add_speed_digit(input logic [7:0] ch);
      logic [63:0] nxt;
      nxt = {32'd0, mag} * 64'd10 + {56'd0, ch - CHAR_ZERO};
      if (nxt > {32'd0, MAG_LIMIT}) begin
         ovf = 1'b1;
         mag = MAG_LIMIT;
      end else begin
         mag = nxt[31:0];
      end
   endfunction

   // apply one accepted byte; a terminator may queue a speed word
   task automatic take_rx_byte(input logic [7:0] ch);
      speed_word_type w;
      bit dig;
      bit blank;
      dig = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
      blank = (ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_VT) || (ch == CHAR_FF);
      if (ch == CHAR_CR || ch == CHAR_LF) begin
         if (phase == PH_DIGITS || phase == PH_DONE) begin
            w.clamped = 1'b0;
            if (neg) begin
               if (ovf) begin
                  w.speed = MAG_LIMIT;
                  w.clamped = 1'b1;
               end else begin
                  w.speed = '0 - mag;
               end
            end else if (ovf || mag > POS_MAX) begin
               w.speed = POS_MAX;
               w.clamped = 1'b1;
            end else begin
               w.speed = mag;
            end
            speed_words.push_back(w);
         end
         clear_line_state();
      end else if (line_len < LineCap - 1) begin
         // bytes past the line capacity are dropped unseen
         line_len++;
         if (ch == CHAR_NUL) begin
            phase = (phase == PH_DIGITS || phase == PH_DONE) ? PH_DONE : PH_REJECT;
         end else begin
            case (phase)
               PH_PREFIX: begin
                  if (ch == tag_char(tag_pos)) begin
                     tag_pos++;
                     if (tag_pos == TagLen) phase = PH_BLANKS;
                  end else begin
                     phase = PH_REJECT;
                  end
               end
               PH_BLANKS: begin
                  if (blank) begin
                     phase = PH_BLANKS;
                  end else if (ch == CHAR_PLUS) begin
                     phase = PH_SIGN;
                  end else if (ch == CHAR_MINUS) begin
                     neg = 1'b1;
                     phase = PH_SIGN;
                  end else if (dig) begin
                     add_speed_digit(ch);
                     phase = PH_DIGITS;
                  end else begin
                     phase = PH_REJECT;
                  end
               end
               PH_SIGN: begin
                  if (dig) begin
                     add_speed_digit(ch);
                     phase = PH_DIGITS;
                  end else begin
                     phase = PH_REJECT;
                  end
               end
               PH_DIGITS: begin
                  if (dig) add_speed_digit(ch);
                  else phase = PH_DONE;
               end
               default: ;
            endcase
         end
      end
   endtask

   // ------------------------------------------------------------------
   // byte sender
   // ------------------------------------------------------------------

   // called at a rising edge, returns at the edge where the word was taken
   task automatic send_byte(input logic [7:0] ch);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ch;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      take_rx_byte(ch);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // any byte that does not end the line
   function automatic logic [7:0] content_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   // stop offering and wait for every predicted word to come out
   task automatic wait_for_speed_words();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (speed_words.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // result receiver and checker
   // ------------------------------------------------------------------

   // rsp_tready: random stall bursts, or one long hold-off on request
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_cycles) @(posedge clock);
            hold_cycles = 0;
         end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // every word taken on rsp is matched against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (speed_words.size() == 0) begin
            fault_count++;
            if (fault_count <= ReportLimit)
               $display("unexpected speed word %0d clamped %0b", rsp_tdata, rsp_tuser);
         end else begin
            want = speed_words.pop_front();
            words_checked++;
            if (rsp_tuser === 1'b1) words_clamped++;
            if (rsp_tdata !== want.speed || rsp_tuser !== want.clamped) begin
               fault_count++;
               if (fault_count <= ReportLimit)
                  $display("speed word mismatch: expected %0d clamped %0b, got %0d clamped %0b",
                           want.speed, want.clamped, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   // watchdog on total run length
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // signed range limits and clamping on both sides
   task automatic test_number_limits();
      send_text("@speed%0\r");
      send_text("@speed%2147483647\n");
      send_text("@speed%2147483648\r");
      send_text("@speed%-2147483648\r");
      send_text("@speed%-2147483649\n");
      send_text("@speed%+000000099999999999\r");
   endtask

   // blank kinds, signs, trailing text and rejected prefixes
   task automatic test_blanks_and_signs();
      send_text("@speed% \t");
      send_byte(CHAR_VT);
      send_byte(CHAR_FF);
      send_text("+12abc\r");
      send_text("@speed%-7 8\n");
      send_text("@speed%+\r");
      send_text("@speed%-x5\r");
      send_text("@speed%x5\r");
      send_text(" @speed%5\r");
      send_text("@Speed%5\r");
      send_text("@speed%");
      send_byte(8'hff);
      send_text("1\r");
   endtask

   // empty lines, CR LF pairs and NUL in the prefix, blank, sign, digit and done phases
   task automatic test_line_breaks_and_nul();
      send_text("\r\n\n");
      send_text("@speed%42\r\n");
      send_text("@spe\r@speed%1\r");
      send_text("@speed%12");
      send_byte(CHAR_NUL);
      send_text("34\r");
      send_text("@speed%");
      send_byte(CHAR_NUL);
      send_text("9\r");
      send_text("@spe");
      send_byte(CHAR_NUL);
      send_text("ed%5\n");
      send_text("@speed%-");
      send_byte(CHAR_NUL);
      send_text("3\r");
      send_text("@speed%8x");
      send_byte(CHAR_NUL);
      send_text("\r");
   endtask

   // lines that run into the capacity limit
   task automatic test_long_lines();
      send_text("@speed%7");
      repeat (140) send_byte(content_byte());
      send_text("\r");
      // digit lands on the last examined byte
      send_text("@speed%");
      repeat (LineCap - 9) send_byte(CHAR_SPACE);
      send_text("5\r");
      // digit falls one byte past the limit
      send_text("@speed%");
      repeat (LineCap - 8) send_byte(CHAR_SPACE);
      send_text("5\n");
      // number cut short by the limit
      send_text("@speed%");
      repeat (LineCap - 10) send_byte(CHAR_SPACE);
      send_text("-45\r");
   endtask

   // receiver holds off long enough for the input to back up
   task automatic test_output_hold_off();
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      hold_cycles = 150;
      for (int i = 0; i < 8; i++) send_text($sformatf("@speed%%%0d\r", i * 1111));
      wait_for_speed_words();
   endtask

   task automatic send_random_line();
      int kind;
      int n;
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
         // well formed command with random content
         send_text("@speed%");
         if ($urandom_range(0, 1)) begin
            repeat ($urandom_range(1, 3)) begin
               case ($urandom_range(0, 3))
                  0: send_byte(CHAR_SPACE);
                  1: send_byte(CHAR_TAB);
                  2: send_byte(CHAR_VT);
                  default: send_byte(CHAR_FF);
               endcase
            end
         end
         case ($urandom_range(0, 2))
            1: send_byte(CHAR_PLUS);
            2: send_byte(CHAR_MINUS);
            default: ;
         endcase
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: send_text("2147483647");
               1: send_text("2147483648");
               2: send_text("2147483649");
               default: send_text("0");
            endcase
         end else begin
            n = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 12 : 5);
            repeat (n) send_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
         end
         if ($urandom_range(0, 9) == 0) send_byte(CHAR_NUL);
         if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 4)) send_byte(content_byte());
      end else if (kind < 88) begin
         // prefix broken at a random spot
         n = $urandom_range(0, TagLen - 1);
         for (int i = 0; i < n; i++) send_byte(tag_char(i));
         send_byte(content_byte());
         send_text("42");
      end else if (kind < 97) begin
         // raw noise, terminators included
         repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
      end else begin
         // long line, digits may fall past the capacity
         send_text("@speed%");
         repeat ($urandom_range(LineCap - 18, LineCap - 3)) send_byte(CHAR_SPACE);
         repeat ($urandom_range(1, 15)) send_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
      end
      case ($urandom_range(0, 3))
         0: send_byte(CHAR_CR);
         1: send_byte(CHAR_LF);
         2: send_text("\r\n");
         default: send_text("\n\r");
      endcase
   endtask

   // random lines until the byte budget is spent; idling switches per line
   task automatic test_random_lines(input int byte_goal, input bit with_idling);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < byte_goal) begin
         gaps_on = with_idling && ($urandom_range(0, 3) != 0);
         stalls_on = with_idling && ($urandom_range(0, 3) != 0);
         send_random_line();
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      clear_line_state();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      gaps_on = 1'b1;
      stalls_on = 1'b1;
      test_number_limits();
      test_blanks_and_signs();
      test_line_breaks_and_nul();
      test_long_lines();
      test_output_hold_off();
      test_random_lines(220, 1'b1);
      // sender pauses until the output has fully drained
      wait_for_speed_words();
      test_random_lines(180, 1'b1);
      // closing stretch runs at full rate on both sides
      test_random_lines(100, 1'b0);

      wait_for_speed_words();
      repeat (8) @(posedge clock);
      fault_count += speed_words.size();

      $display("sent %0d bytes: limits, blanks, signs, NUL, CR/LF, long lines, hold-off",
               bytes_sent);
      $display("checked %0d speed words, %0d of them clamped", words_checked, words_clamped);
      if (fault_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
